### rtl/core/sls_pkg.sv
`default_nettype none

package sls_pkg;

  // Width of each nesting counter
  localparam int unsigned DEPTH_BITS = 8;

  typedef logic [DEPTH_BITS-1:0] level_t;

  localparam level_t DEPTH_MAX = '1;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  // Byte codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_t;

  // Scanner state carried from byte to byte
  typedef struct packed {
    quote_t quote_mode;
    logic   escape_pending;
    logic   in_backtick;
    level_t paren_level;
    level_t brace_level;
    logic   at_word_start;
    logic   after_dollar;
    logic   after_dollar_paren;
    logic   failed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    quote_mode:         QUOTE_NONE,
    escape_pending:     1'b0,
    in_backtick:        1'b0,
    paren_level:        '0,
    brace_level:        '0,
    at_word_start:      1'b1,
    after_dollar:       1'b0,
    after_dollar_paren: 1'b0,
    failed:             1'b0
  };

endpackage

`default_nettype wire

### rtl/core/sls_step.sv
`default_nettype none

// Next scanner state for one list byte
module sls_step (
  input  wire sls_pkg::scan_state_t st,
  input  wire logic [7:0]           list_byte,
  output sls_pkg::scan_state_t      nx,
  output logic                      safe_now
);

  logic structural;
  logic blank;

  assign structural = (list_byte == sls_pkg::CH_RPAREN) || (list_byte == sls_pkg::CH_LPAREN) ||
                      (list_byte == sls_pkg::CH_SEMI)   || (list_byte == sls_pkg::CH_PIPE)   ||
                      (list_byte == sls_pkg::CH_AMP)    || (list_byte == sls_pkg::CH_LT)     ||
                      (list_byte == sls_pkg::CH_GT)     || (list_byte == sls_pkg::CH_NL);
  assign blank      = (list_byte == sls_pkg::CH_SPACE) || (list_byte == sls_pkg::CH_TAB);

  always_comb begin
    nx = st;
    nx.after_dollar       = 1'b0;
    nx.after_dollar_paren = 1'b0;
    if (st.escape_pending) begin
      // escaped byte is plain
      nx.escape_pending = 1'b0;
      nx.at_word_start  = 1'b0;
    end else if (st.quote_mode != sls_pkg::QUOTE_NONE) begin
      // inside quotes only the matching quote matters
      if ((st.quote_mode == sls_pkg::QUOTE_SINGLE && list_byte == sls_pkg::CH_SQUOTE) ||
          (st.quote_mode == sls_pkg::QUOTE_DOUBLE && list_byte == sls_pkg::CH_DQUOTE)) begin
        nx.quote_mode = sls_pkg::QUOTE_NONE;
      end
      nx.at_word_start = 1'b0;
    end else if ((st.after_dollar_paren || st.after_dollar) && list_byte == sls_pkg::CH_LPAREN) begin
      // $( or the second ( of $((
      if (st.paren_level == sls_pkg::DEPTH_MAX) begin
        nx.failed = 1'b1;
      end else begin
        nx.paren_level = st.paren_level + 1'b1;
      end
      nx.after_dollar_paren = ~st.after_dollar_paren;
      nx.at_word_start      = 1'b0;
    end else if (st.after_dollar && list_byte == sls_pkg::CH_LBRACE) begin
      if (st.brace_level == sls_pkg::DEPTH_MAX) begin
        nx.failed = 1'b1;
      end else begin
        nx.brace_level = st.brace_level + 1'b1;
      end
      nx.at_word_start = 1'b0;
    end else if (list_byte == sls_pkg::CH_BSLASH) begin
      nx.escape_pending = 1'b1;
      nx.at_word_start  = 1'b0;
    end else begin
      // plain byte at the current nesting
      if (list_byte == sls_pkg::CH_SQUOTE) begin
        nx.quote_mode = sls_pkg::QUOTE_SINGLE;
      end else if (list_byte == sls_pkg::CH_DQUOTE) begin
        nx.quote_mode = sls_pkg::QUOTE_DOUBLE;
      end else if (list_byte == sls_pkg::CH_BTICK) begin
        nx.in_backtick = ~st.in_backtick;
      end else if (list_byte == sls_pkg::CH_DOLLAR) begin
        nx.after_dollar = 1'b1;
      end else if (list_byte == sls_pkg::CH_RPAREN && st.paren_level != '0) begin
        nx.paren_level = st.paren_level - 1'b1;
      end else if (list_byte == sls_pkg::CH_RBRACE && st.brace_level != '0) begin
        nx.brace_level = st.brace_level - 1'b1;
      end else if (!st.in_backtick && st.paren_level == '0 && st.brace_level == '0) begin
        if (structural || (list_byte == sls_pkg::CH_HASH && st.at_word_start)) begin
          nx.failed = 1'b1;
        end
      end
      nx.at_word_start = blank;
    end
  end

  // Verdict if this byte closes the list
  assign safe_now = !nx.failed && (nx.quote_mode == sls_pkg::QUOTE_NONE) && !nx.in_backtick &&
                    (nx.paren_level == '0) && (nx.brace_level == '0);

endmodule

`default_nettype wire

### rtl/core/shell_list_safety_scanner.sv
// Shell word-list safety scanner.
// Input stream: one list byte per transfer on s_tdata, s_tlast on the final
// byte of a list. Output stream: one verdict per list, m_tdata[0] = 1 when
// the list is safe, 0 when unsafe.
// Every byte is scanned in the cycle it is accepted; a new byte can be taken
// every cycle while the receiver does not stall, so throughput is one byte per
// cycle. The verdict appears on m_tvalid in the cycle after the last byte's
// transfer and is held in an output register until the receiver takes it.
// The scanner state is updated by one combinational step per byte and
// returns to its reset values after each last byte.
// Reset (rst, synchronous) clears the scanner state and drops m_tvalid.
// When the receiver stalls with a verdict pending, s_tready falls and input
// waits; s_tready follows m_tready combinationally in that case.
`default_nettype none

module shell_list_safety_scanner (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [sls_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] list_byte
  input  wire logic                           s_tlast,   // is_last
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [sls_pkg::OUT_DATA_W-1:0] m_tdata    // [0] safe, [7:1] zero
);

  sls_pkg::scan_state_t st;
  sls_pkg::scan_state_t st_next;
  logic                 safe_now;
  logic                 safe;
  logic                 in_xfer;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  sls_step u_step (
    .st        (st),
    .list_byte (s_tdata),
    .nx        (st_next),
    .safe_now  (safe_now)
  );

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sls_pkg::SCAN_RESET;
    end else if (in_xfer) begin
      st <= s_tlast ? sls_pkg::SCAN_RESET : st_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      safe <= safe_now;
    end
  end

  assign m_tdata = {{(sls_pkg::OUT_DATA_W-1){1'b0}}, safe};

`ifndef SYNTH
  // a last byte always yields a pending verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tlast |=> m_tvalid)
    else $error("no verdict after last byte");

  // state is back at reset after each list
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tlast |=> st == sls_pkg::SCAN_RESET)
    else $error("scanner state not cleared after list");

  // failure stays set until the list ends
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    st.failed && !(in_xfer && s_tlast) |=> st.failed)
    else $error("failure flag dropped inside a list");
`endif

endmodule

`default_nettype wire
